>>> rtl/core/tofsq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tagged oldest-first slot queue: shared definitions
// Item and result layouts, operation codes, status codes and engine states.
// ----------------------------------------------------------------------------
package tofsq_pkg;

    // Most results one discard item may produce.
    localparam int MAX_RESULTS = 16;
    localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_TAKE    = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_DISCARD = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NONE    = 2'd1,
        ST_CLAIMED = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_CHECK,
        S_READ,
        S_EMIT,
        S_FLUSH
    } state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  owner_tag;
        logic [31:0] buffer_handle;
        logic [19:0] msg_length;
        logic [3:0]  slot_select;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot_index;
        logic [7:0]  out_owner;
        logic [31:0] out_handle;
        logic [19:0] out_length;
        logic        evicted;
        logic        overflow_seen;
        logic        last;
    } result_t;

    // Classified command handed from the front part to the engine.
    typedef struct packed {
        op_t         op;
        logic        bad_enqueue;
        logic [7:0]  owner_tag;
        logic [31:0] buffer_handle;
        logic [19:0] msg_length;
        logic [3:0]  slot_select;
    } cmd_t;

endpackage

>>> rtl/core/tofsq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tagged oldest-first slot queue: front part
// Accepts items, classifies them and holds them in a two-entry command queue.
// ----------------------------------------------------------------------------
module tofsq_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  tofsq_pkg::item_t item,
    output logic             cmd_valid,
    input  logic             cmd_ready,
    output tofsq_pkg::cmd_t  cmd
);

    tofsq_pkg::cmd_t q_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      cnt_reg, cnt_next;
    tofsq_pkg::cmd_t classified;
    logic            do_push, do_pop;

    always_comb
    begin
        classified.op            = tofsq_pkg::op_t'(item.kind);
        classified.bad_enqueue   = (tofsq_pkg::op_t'(item.kind) == tofsq_pkg::OP_ENQUEUE)
                                   && (item.owner_tag == 8'd0 || item.msg_length == 20'd0);
        classified.owner_tag     = item.owner_tag;
        classified.buffer_handle = item.buffer_handle;
        classified.msg_length    = item.msg_length;
        classified.slot_select   = item.slot_select;
    end

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

>>> rtl/core/tofsq_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tagged oldest-first slot queue: engine
// Holds the slot ring and carries out one command at a time by scanning the
// slots one per cycle (a clear skips the scan), then reading and updating the chosen slot.
// ----------------------------------------------------------------------------
module tofsq_engine
#(
    parameter int SLOT_COUNT = 16,
    parameter int SEQ_BITS   = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  tofsq_pkg::cmd_t    cmd,
    output logic               res_push,
    input  logic               res_full,
    output tofsq_pkg::result_t res
);

    localparam int IW = $clog2(SLOT_COUNT);
    localparam logic [SEQ_BITS-1:0] BUSY = {SEQ_BITS{1'b1}};
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);
    localparam logic [tofsq_pkg::COUNT_W-1:0] CNT_LIMIT =
        tofsq_pkg::COUNT_W'(tofsq_pkg::MAX_RESULTS - 1);

    // Slot ring: owner and stamp reset, handle and length in a memory.
    logic [7:0]          owner_reg [SLOT_COUNT];
    logic [SEQ_BITS-1:0] seq_reg   [SLOT_COUNT];
    logic [31:0]         handle_mem [SLOT_COUNT];
    logic [19:0]         length_mem [SLOT_COUNT];
    logic [31:0]         rd_handle_reg;
    logic [19:0]         rd_length_reg;

    tofsq_pkg::state_t   state_reg, state_next;
    tofsq_pkg::cmd_t     cmd_reg, cmd_next;
    logic [IW-1:0]       scan_idx_reg, scan_idx_next;
    logic                free_found_reg, free_found_next;
    logic [IW-1:0]       free_idx_reg, free_idx_next;
    logic                best_found_reg, best_found_next;
    logic [IW-1:0]       best_idx_reg, best_idx_next;
    logic [SEQ_BITS-1:0] best_seq_reg, best_seq_next;
    logic [IW-1:0]       target_reg, target_next;
    tofsq_pkg::status_t  status_reg, status_next;
    logic                from_slot_reg, from_slot_next;
    logic                show_slot_reg, show_slot_next;
    logic                evict_reg, evict_next;
    logic [SEQ_BITS-1:0] next_seq_reg, next_seq_next;
    logic                overflow_reg, overflow_next;
    logic [tofsq_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                held_valid_reg, held_valid_next;
    tofsq_pkg::result_t  held_reg, held_next;

    logic [IW-1:0]       rd_idx;
    logic [7:0]          rd_owner;
    logic [SEQ_BITS-1:0] rd_seq;
    logic                pending, eligible;
    logic [SEQ_BITS-1:0] seq_inc, stamp, seq_after;
    tofsq_pkg::result_t  built;

    logic                slot_we, busy_we, free_we;
    logic [IW-1:0]       wr_idx;

    assign rd_idx   = (state_reg == tofsq_pkg::S_SCAN) ? scan_idx_reg : target_reg;
    assign rd_owner = owner_reg[rd_idx];
    assign rd_seq   = seq_reg[rd_idx];
    assign pending  = (rd_owner != 8'd0) && (rd_seq != BUSY);
    assign eligible = pending && (cmd_reg.op != tofsq_pkg::OP_TAKE
                                  || cmd_reg.owner_tag == 8'd0
                                  || cmd_reg.owner_tag == rd_owner);

    // Stamp for a new message; the counter steps over the busy marker.
    always_comb
    begin
        seq_inc = next_seq_reg + {{(SEQ_BITS-1){1'b0}}, 1'b1};
        if (next_seq_reg == BUSY)
        begin
            stamp     = seq_inc;
            seq_after = seq_inc + {{(SEQ_BITS-1){1'b0}}, 1'b1};
        end
        else
        begin
            stamp     = next_seq_reg;
            seq_after = seq_inc;
        end
    end

    always_comb
    begin
        built.status        = status_reg;
        built.slot_index    = show_slot_reg ? 4'(target_reg) : 4'd0;
        built.out_owner     = from_slot_reg ? rd_owner : 8'd0;
        built.out_handle    = from_slot_reg ? rd_handle_reg : 32'd0;
        built.out_length    = from_slot_reg ? rd_length_reg : 20'd0;
        built.evicted       = evict_reg;
        built.overflow_seen = overflow_reg;
        built.last          = 1'b1;
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        scan_idx_next   = scan_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_seq_next   = best_seq_reg;
        target_next     = target_reg;
        status_next     = status_reg;
        from_slot_next  = from_slot_reg;
        show_slot_next  = show_slot_reg;
        evict_next      = evict_reg;
        next_seq_next   = next_seq_reg;
        overflow_next   = overflow_reg;
        count_next      = count_reg;
        held_valid_next = held_valid_reg;
        held_next       = held_reg;
        cmd_ready       = 1'b0;
        res_push        = 1'b0;
        res             = built;
        slot_we         = 1'b0;
        busy_we         = 1'b0;
        free_we         = 1'b0;
        wr_idx          = target_reg;

        case (state_reg)
            tofsq_pkg::S_IDLE:
            begin
                cmd_ready       = 1'b1;
                scan_idx_next   = '0;
                free_found_next = 1'b0;
                best_found_next = 1'b0;
                best_seq_next   = BUSY;
                evict_next      = 1'b0;
                from_slot_next  = 1'b0;
                show_slot_next  = 1'b0;
                count_next      = '0;
                held_valid_next = 1'b0;
                if (cmd_valid)
                begin
                    cmd_next    = cmd;
                    target_next = IW'(cmd.slot_select);
                    case (cmd.op)
                        tofsq_pkg::OP_ENQUEUE:
                        begin
                            if (cmd.bad_enqueue)
                            begin
                                status_next = tofsq_pkg::ST_INVALID;
                                state_next  = tofsq_pkg::S_EMIT;
                            end
                            else
                            begin
                                state_next = tofsq_pkg::S_SCAN;
                            end
                        end
                        tofsq_pkg::OP_CLEAR:
                        begin
                            if (32'(cmd.slot_select) >= SLOT_COUNT)
                            begin
                                status_next = tofsq_pkg::ST_INVALID;
                                state_next  = tofsq_pkg::S_EMIT;
                            end
                            else
                            begin
                                state_next = tofsq_pkg::S_CHECK;
                            end
                        end
                        default:
                        begin
                            state_next = tofsq_pkg::S_SCAN;
                        end
                    endcase
                end
            end

            tofsq_pkg::S_SCAN:
            begin
                if (!free_found_reg && rd_owner == 8'd0)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = scan_idx_reg;
                end
                if (eligible && rd_seq < best_seq_reg)
                begin
                    best_found_next = 1'b1;
                    best_idx_next   = scan_idx_reg;
                    best_seq_next   = rd_seq;
                end
                scan_idx_next = scan_idx_reg + {{(IW-1){1'b0}}, 1'b1};
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = tofsq_pkg::S_DECIDE;
                end
            end

            tofsq_pkg::S_DECIDE:
            begin
                status_next    = tofsq_pkg::ST_OK;
                show_slot_next = 1'b1;
                from_slot_next = 1'b1;
                target_next    = best_idx_reg;
                case (cmd_reg.op)
                    tofsq_pkg::OP_ENQUEUE:
                    begin
                        if (free_found_reg)
                        begin
                            // Free slot: fill it now, report without contents.
                            slot_we        = 1'b1;
                            wr_idx         = free_idx_reg;
                            next_seq_next  = seq_after;
                            target_next    = free_idx_reg;
                            from_slot_next = 1'b0;
                            state_next     = tofsq_pkg::S_EMIT;
                        end
                        else
                        begin
                            overflow_next = 1'b1;
                            if (best_found_reg)
                            begin
                                evict_next = 1'b1;
                                state_next = tofsq_pkg::S_READ;
                            end
                            else
                            begin
                                status_next    = tofsq_pkg::ST_CLAIMED;
                                show_slot_next = 1'b0;
                                from_slot_next = 1'b0;
                                state_next     = tofsq_pkg::S_EMIT;
                            end
                        end
                    end
                    default:
                    begin
                        if (best_found_reg)
                        begin
                            state_next = tofsq_pkg::S_READ;
                        end
                        else if (held_valid_reg)
                        begin
                            state_next = tofsq_pkg::S_FLUSH;
                        end
                        else
                        begin
                            status_next    = tofsq_pkg::ST_NONE;
                            show_slot_next = 1'b0;
                            from_slot_next = 1'b0;
                            state_next     = tofsq_pkg::S_EMIT;
                        end
                    end
                endcase
            end

            tofsq_pkg::S_CHECK:
            begin
                if (rd_owner != 8'd0 && rd_seq == BUSY)
                begin
                    status_next    = tofsq_pkg::ST_OK;
                    show_slot_next = 1'b1;
                    from_slot_next = 1'b1;
                    state_next     = tofsq_pkg::S_READ;
                end
                else
                begin
                    status_next = tofsq_pkg::ST_INVALID;
                    state_next  = tofsq_pkg::S_EMIT;
                end
            end

            tofsq_pkg::S_READ:
            begin
                state_next = tofsq_pkg::S_EMIT;
            end

            tofsq_pkg::S_EMIT:
            begin
                if (cmd_reg.op == tofsq_pkg::OP_DISCARD && from_slot_reg)
                begin
                    // The previous discard result goes out once the next is known.
                    if (!(held_valid_reg && res_full))
                    begin
                        res_push        = held_valid_reg;
                        res             = held_reg;
                        res.last        = 1'b0;
                        held_next       = built;
                        held_valid_next = 1'b1;
                        free_we         = 1'b1;
                        count_next      = count_reg + {{(tofsq_pkg::COUNT_W-1){1'b0}}, 1'b1};
                        scan_idx_next   = '0;
                        free_found_next = 1'b0;
                        best_found_next = 1'b0;
                        best_seq_next   = BUSY;
                        if (count_reg == CNT_LIMIT)
                        begin
                            state_next = tofsq_pkg::S_FLUSH;
                        end
                        else
                        begin
                            state_next = tofsq_pkg::S_SCAN;
                        end
                    end
                end
                else if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = tofsq_pkg::S_IDLE;
                    if (status_reg == tofsq_pkg::ST_OK && from_slot_reg)
                    begin
                        case (cmd_reg.op)
                            tofsq_pkg::OP_ENQUEUE:
                            begin
                                slot_we       = 1'b1;
                                next_seq_next = seq_after;
                            end
                            tofsq_pkg::OP_TAKE:
                            begin
                                busy_we = 1'b1;
                            end
                            default:
                            begin
                                free_we = 1'b1;
                            end
                        endcase
                    end
                end
            end

            tofsq_pkg::S_FLUSH:
            begin
                if (!res_full)
                begin
                    res_push        = 1'b1;
                    res             = held_reg;
                    res.last        = 1'b1;
                    held_valid_next = 1'b0;
                    state_next      = tofsq_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = tofsq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tofsq_pkg::S_IDLE;
            next_seq_reg   <= '0;
            overflow_reg   <= 1'b0;
            held_valid_reg <= 1'b0;
            count_reg      <= '0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                owner_reg[i] <= 8'd0;
                seq_reg[i]   <= BUSY;
            end
        end
        else
        begin
            state_reg      <= state_next;
            next_seq_reg   <= next_seq_next;
            overflow_reg   <= overflow_next;
            held_valid_reg <= held_valid_next;
            count_reg      <= count_next;
            if (slot_we)
            begin
                owner_reg[wr_idx] <= cmd_reg.owner_tag;
                seq_reg[wr_idx]   <= stamp;
            end
            else if (busy_we)
            begin
                seq_reg[wr_idx] <= BUSY;
            end
            else if (free_we)
            begin
                owner_reg[wr_idx] <= 8'd0;
                seq_reg[wr_idx]   <= BUSY;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        scan_idx_reg   <= scan_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        best_found_reg <= best_found_next;
        best_idx_reg   <= best_idx_next;
        best_seq_reg   <= best_seq_next;
        target_reg     <= target_next;
        status_reg     <= status_next;
        from_slot_reg  <= from_slot_next;
        show_slot_reg  <= show_slot_next;
        evict_reg      <= evict_next;
        held_reg       <= held_next;
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            handle_mem[wr_idx] <= cmd_reg.buffer_handle;
            length_mem[wr_idx] <= cmd_reg.msg_length;
        end
        rd_handle_reg <= handle_mem[target_reg];
        rd_length_reg <= length_mem[target_reg];
    end

endmodule

>>> rtl/core/tofsq_result_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tagged oldest-first slot queue: result queue
// Two-entry queue that parts the engine from the result consumer.
// ----------------------------------------------------------------------------
module tofsq_result_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               res_push,
    output logic               res_full,
    input  tofsq_pkg::result_t res,
    output logic               empty,
    input  logic               pop,
    output tofsq_pkg::result_t result
);

    tofsq_pkg::result_t q_reg [2];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign res_full = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign result   = q_reg[rd_ptr_reg];
    assign do_push  = res_push && !res_full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= res;
        end
    end

endmodule

>>> rtl/core/tagged_oldest_first_slot_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tagged oldest-first slot queue
// Ring of message slots with enqueue, take, clear and discard operations.
// ----------------------------------------------------------------------------
// Usage. Items enter through a queue-style port: an item is taken at a rising
// edge with push high and full low. Results leave the same way: the oldest
// result sits on result while empty is low and is taken when pop is high.
// A front part classifies each item into a two-entry command queue; the
// engine behind it works on one command at a time; a two-entry result queue
// decouples the engine from the consumer, so new items are taken while
// results still wait.
// Sequence. An engine scan visits one slot per cycle. An enqueue into a free
// slot goes through the scan, a decide step and an emit step; a take or an
// evicting enqueue adds a slot read before the emit; a rejected enqueue or a
// clear skips the scan. Discard repeats the scan once per evicted slot, up to
// MAX_RESULTS times, plus one last scan to find that nothing is left unless
// that limit is reached. The slot scan sets the rate.
// Reset. All slots become free, the stamp counter and the sticky overflow
// flag clear, and both queues empty. No clearing pass is needed.
// Stalls. When the consumer stops popping, the result queue fills, the
// engine holds its pending result, and then the command queue backs up.
// ----------------------------------------------------------------------------
module tagged_oldest_first_slot_queue_core
#(
    parameter int SLOT_COUNT = 16,
    parameter int SEQ_BITS   = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  tofsq_pkg::item_t   item,
    output logic               empty,
    input  logic               pop,
    output tofsq_pkg::result_t result
);

    logic               cmd_valid;
    logic               cmd_ready;
    tofsq_pkg::cmd_t    cmd;
    logic               res_push;
    logic               res_full;
    tofsq_pkg::result_t res;

    tofsq_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    tofsq_engine
    #(
        .SLOT_COUNT (SLOT_COUNT),
        .SEQ_BITS   (SEQ_BITS)
    )
    u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_push  (res_push),
        .res_full  (res_full),
        .res       (res)
    );

    tofsq_result_queue u_result_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_full (res_full),
        .res      (res),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

`ifndef SYNTHESIS
    // The engine must never offer a result that the result queue cannot hold.
    assert property (@(posedge clk) disable iff (!rst_n) res_push |-> !res_full)
        else $error("engine pushed a result into a full result queue");

    // The overflow flag is sticky, so every later result carries it too.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && result.overflow_seen) |=> (empty || result.overflow_seen))
        else $error("overflow flag dropped after being reported");

    // Only a discard produces results that are not last, and those are all ok.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.last) |-> (result.status == tofsq_pkg::ST_OK))
        else $error("non-final result with a failure status");
`endif

endmodule

>>> bench/tb_tagged_oldest_first_slot_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the tagged oldest-first slot queue
// Directed and random enqueue, take, clear and discard items are offered with
// random gaps on both sides. A behavioural copy of the slot ring predicts each
// result, and every popped result is checked field by field against the
// oldest prediction.
// ----------------------------------------------------------------------------
module tb_tagged_oldest_first_slot_queue_core;

    localparam int SLOTS      = 16;
    localparam logic [31:0] BUSY_STAMP = 32'hFFFF_FFFF;
    localparam int CYCLE_LIMIT = 400000;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    tofsq_pkg::item_t   item;
    logic               empty;
    logic               pop;
    tofsq_pkg::result_t result;

    tagged_oldest_first_slot_queue_core dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Shadow copy of the slot ring, updated as each item is accepted.
    logic [7:0]  ring_owner  [SLOTS];
    logic [31:0] ring_stamp  [SLOTS];
    logic [31:0] ring_handle [SLOTS];
    logic [19:0] ring_length [SLOTS];
    logic [31:0] stamp_counter;
    logic        sticky_overflow;

    tofsq_pkg::item_t   pending_items[$];
    tofsq_pkg::result_t expected_results[$];

    int  error_count;
    int  items_sent;
    int  results_seen;
    int  cycle_count;
    int  evictions_seen;
    int  stall_clock;       // cycles since reset, paces the long receiver stall
    bit  hold_off;          // high during the long receiver stall

    function automatic bit slot_pending(int i);
        return ring_owner[i] != 8'd0 && ring_stamp[i] != BUSY_STAMP;
    endfunction

    // Oldest pending slot for an owner (0 matches any), or -1 if none.
    function automatic int oldest_pending(logic [7:0] who);
        int best;
        logic [31:0] best_stamp;
        best = -1;
        best_stamp = BUSY_STAMP;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slot_pending(i) && (who == 8'd0 || ring_owner[i] == who)
                && ring_stamp[i] < best_stamp)
            begin
                best_stamp = ring_stamp[i];
                best = i;
            end
        end
        return best;
    endfunction

    function automatic tofsq_pkg::result_t slot_result(tofsq_pkg::status_t st, int idx,
                                                       bit from_slot, bit evict, bit fin);
        tofsq_pkg::result_t r;
        r = '0;
        r.status = st;
        if (idx >= 0)
        begin
            r.slot_index = idx[3:0];
            if (from_slot)
            begin
                r.out_owner  = ring_owner[idx];
                r.out_handle = ring_handle[idx];
                r.out_length = ring_length[idx];
            end
        end
        r.evicted = evict;
        r.overflow_seen = sticky_overflow;
        r.last = fin;
        return r;
    endfunction

    function automatic void release_slot(int i);
        ring_owner[i]  = 8'd0;
        ring_stamp[i]  = BUSY_STAMP;
        ring_handle[i] = '0;
        ring_length[i] = '0;
    endfunction

    // Works out the results of one accepted item and queues them.
    function automatic void predict_slot_ops(tofsq_pkg::item_t it);
        int idx;
        int n;
        bit victim;
        logic [31:0] stamp;
        case (tofsq_pkg::op_t'(it.kind))
            tofsq_pkg::OP_ENQUEUE:
            begin
                if (it.owner_tag == 8'd0 || it.msg_length == 20'd0)
                begin
                    expected_results.push_back(slot_result(tofsq_pkg::ST_INVALID, -1,
                                                           0, 0, 1));
                    return;
                end
                idx = -1;
                victim = 0;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (idx < 0 && ring_owner[i] == 8'd0)
                    begin
                        idx = i;
                    end
                end
                if (idx < 0)
                begin
                    sticky_overflow = 1'b1;
                    idx = oldest_pending(8'd0);
                    if (idx < 0)
                    begin
                        expected_results.push_back(slot_result(tofsq_pkg::ST_CLAIMED, -1,
                                                               0, 0, 1));
                        return;
                    end
                    victim = 1;
                    expected_results.push_back(slot_result(tofsq_pkg::ST_OK, idx, 1, 1, 1));
                end
                // The counter never hands out the busy marker.
                stamp = stamp_counter;
                stamp_counter = stamp_counter + 32'd1;
                if (stamp == BUSY_STAMP)
                begin
                    stamp = stamp_counter;
                    stamp_counter = stamp_counter + 32'd1;
                end
                ring_owner[idx]  = it.owner_tag;
                ring_stamp[idx]  = stamp;
                ring_handle[idx] = it.buffer_handle;
                ring_length[idx] = it.msg_length;
                if (!victim)
                begin
                    expected_results.push_back(slot_result(tofsq_pkg::ST_OK, idx, 0, 0, 1));
                end
            end
            tofsq_pkg::OP_TAKE:
            begin
                idx = oldest_pending(it.owner_tag);
                if (idx < 0)
                begin
                    expected_results.push_back(slot_result(tofsq_pkg::ST_NONE, -1, 0, 0, 1));
                end
                else
                begin
                    ring_stamp[idx] = BUSY_STAMP;
                    expected_results.push_back(slot_result(tofsq_pkg::ST_OK, idx, 1, 0, 1));
                end
            end
            tofsq_pkg::OP_CLEAR:
            begin
                idx = int'(it.slot_select);
                if (ring_owner[idx] == 8'd0 || ring_stamp[idx] != BUSY_STAMP)
                begin
                    expected_results.push_back(slot_result(tofsq_pkg::ST_INVALID, -1,
                                                           0, 0, 1));
                end
                else
                begin
                    expected_results.push_back(slot_result(tofsq_pkg::ST_OK, idx, 1, 0, 1));
                    release_slot(idx);
                end
            end
            default:
            begin
                n = 0;
                idx = oldest_pending(8'd0);
                while (n < tofsq_pkg::MAX_RESULTS && idx >= 0)
                begin
                    n++;
                    expected_results.push_back(slot_result(tofsq_pkg::ST_OK, idx, 1, 0, 0));
                    release_slot(idx);
                    idx = oldest_pending(8'd0);
                end
                if (n == 0)
                begin
                    expected_results.push_back(slot_result(tofsq_pkg::ST_NONE, -1, 0, 0, 1));
                end
                else
                begin
                    expected_results[$].last = 1'b1;
                end
            end
        endcase
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        if ($urandom_range(0, 9) == 0)
        begin
            return $urandom_range(10, 40);
        end
        else if ($urandom_range(0, 2) == 0)
        begin
            return 0;
        end
        return $urandom_range(0, 3);
    endfunction

    function automatic tofsq_pkg::item_t make_item(tofsq_pkg::op_t op, logic [7:0] who,
                                                   logic [31:0] handle, logic [19:0] len,
                                                   logic [3:0] sel);
        tofsq_pkg::item_t it;
        it.kind = op;
        it.owner_tag = who;
        it.buffer_handle = handle;
        it.msg_length = len;
        it.slot_select = sel;
        return it;
    endfunction

    function automatic tofsq_pkg::item_t random_item(int owner_span);
        tofsq_pkg::item_t it;
        int pick;
        it.owner_tag = (owner_span == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(1, owner_span));
        it.buffer_handle = $urandom();
        it.msg_length = ($urandom_range(0, 15) == 0) ? 20'd0
                                                     : 20'($urandom_range(1, 20'hFFFFF));
        it.slot_select = 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            it.kind = tofsq_pkg::OP_ENQUEUE;
        end
        else if (pick < 75)
        begin
            it.kind = tofsq_pkg::OP_TAKE;
            if ($urandom_range(0, 2) == 0)
            begin
                it.owner_tag = 8'd0;
            end
        end
        else if (pick < 93)
        begin
            it.kind = tofsq_pkg::OP_CLEAR;
        end
        else
        begin
            it.kind = tofsq_pkg::OP_DISCARD;
        end
        return it;
    endfunction

    // Driver: presents items from pending_items; inputs change on the falling edge.
    int   send_gap;
    logic full_at_edge;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full_at_edge)
            begin
                send_gap <= gap_length();
            end
            if (push && full_at_edge)
            begin
                // Still waiting for the block to take the current item.
            end
            else if (send_gap > 0 && !(push && !full_at_edge))
            begin
                send_gap <= send_gap - 1;
                push <= 1'b0;
            end
            else if ((push && !full_at_edge && gap_length() == 0 || !push)
                     && pending_items.size() > 0)
            begin
                push <= 1'b1;
                item <= pending_items.pop_front();
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // Records at the rising edge whether the offered item was accepted.
    always @(posedge clk)
    begin
        full_at_edge <= full;
        if (rst_n && push && !full)
        begin
            predict_slot_ops(item);
            items_sent <= items_sent + 1;
        end
    end

    // Long receiver stall, counted in cycles from the end of reset.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            stall_clock <= 0;
            hold_off <= 1'b0;
        end
        else
        begin
            stall_clock <= stall_clock + 1;
            hold_off <= (stall_clock >= 200 && stall_clock < 800);
        end
    end

    // Receiver: random pops, held off entirely during the long stall.
    int pop_gap;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_off)
            begin
                pop <= 1'b0;
            end
            else if (pop_gap > 0)
            begin
                pop_gap <= pop_gap - 1;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
                pop_gap <= gap_length();
            end
        end
    end

    // Monitor: checks each popped result against the oldest prediction.
    tofsq_pkg::result_t want;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && pop && !empty)
        begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: status %0d slot %0d", result.status,
                       result.slot_index);
                error_count = error_count + 1;
            end
            else
            begin
                want = expected_results.pop_front();
                if (want.evicted)
                begin
                    evictions_seen <= evictions_seen + 1;
                end
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, result.status);
                    error_count = error_count + 1;
                end
                if (result.slot_index !== want.slot_index)
                begin
                    $error("slot_index: expected %0d, got %0d", want.slot_index,
                           result.slot_index);
                    error_count = error_count + 1;
                end
                if (result.out_owner !== want.out_owner)
                begin
                    $error("out_owner: expected %0h, got %0h", want.out_owner,
                           result.out_owner);
                    error_count = error_count + 1;
                end
                if (result.out_handle !== want.out_handle)
                begin
                    $error("out_handle: expected %0h, got %0h", want.out_handle,
                           result.out_handle);
                    error_count = error_count + 1;
                end
                if (result.out_length !== want.out_length)
                begin
                    $error("out_length: expected %0h, got %0h", want.out_length,
                           result.out_length);
                    error_count = error_count + 1;
                end
                if (result.evicted !== want.evicted)
                begin
                    $error("evicted: expected %0b, got %0b", want.evicted, result.evicted);
                    error_count = error_count + 1;
                end
                if (result.overflow_seen !== want.overflow_seen)
                begin
                    $error("overflow_seen: expected %0b, got %0b", want.overflow_seen,
                           result.overflow_seen);
                    error_count = error_count + 1;
                end
                if (result.last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, result.last);
                    error_count = error_count + 1;
                end
            end
        end
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        tofsq_pkg::item_t it;
        push = 1'b0;
        pop = 1'b0;
        item = '0;
        rst_n = 1'b0;
        send_gap = 0;
        pop_gap = 0;
        full_at_edge = 1'b0;
        error_count = 0;
        items_sent = 0;
        results_seen = 0;
        cycle_count = 0;
        evictions_seen = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            release_slot(i);
        end
        stamp_counter = '0;
        sticky_overflow = 1'b0;

        // Directed part: empty-ring misses, rejected enqueues, field extremes,
        // a take by owner and by any owner, clears of good and bad slots, and
        // a discard that finds nothing pending.
        pending_items.push_back(make_item(tofsq_pkg::OP_TAKE, 8'd0, '0, '0, 4'd0));
        pending_items.push_back(make_item(tofsq_pkg::OP_DISCARD, 8'd0, '0, '0, 4'd0));
        pending_items.push_back(make_item(tofsq_pkg::OP_ENQUEUE, 8'd0, 32'h1234, 20'd5,
                                          4'd0));
        pending_items.push_back(make_item(tofsq_pkg::OP_ENQUEUE, 8'd7, 32'h1234, 20'd0,
                                          4'd0));
        pending_items.push_back(make_item(tofsq_pkg::OP_ENQUEUE, 8'hFF, 32'hFFFF_FFFF,
                                          20'hFFFFF, 4'hF));
        pending_items.push_back(make_item(tofsq_pkg::OP_ENQUEUE, 8'd1, 32'h0, 20'd1, 4'd0));
        pending_items.push_back(make_item(tofsq_pkg::OP_ENQUEUE, 8'hAA, 32'h5555_AAAA,
                                          20'h5A5A5, 4'hA));
        pending_items.push_back(make_item(tofsq_pkg::OP_TAKE, 8'd1, '0, '0, 4'd0));
        pending_items.push_back(make_item(tofsq_pkg::OP_TAKE, 8'd9, '0, '0, 4'd0));
        pending_items.push_back(make_item(tofsq_pkg::OP_TAKE, 8'd0, '0, '0, 4'd5));
        pending_items.push_back(make_item(tofsq_pkg::OP_CLEAR, 8'd0, '0, '0, 4'd1));
        pending_items.push_back(make_item(tofsq_pkg::OP_CLEAR, 8'd0, '0, '0, 4'd1));
        pending_items.push_back(make_item(tofsq_pkg::OP_CLEAR, 8'd0, '0, '0, 4'd2));
        pending_items.push_back(make_item(tofsq_pkg::OP_CLEAR, 8'd0, '0, '0, 4'hF));
        pending_items.push_back(make_item(tofsq_pkg::OP_DISCARD, 8'd3, '0, '0, 4'd0));
        pending_items.push_back(make_item(tofsq_pkg::OP_CLEAR, 8'd0, '0, '0, 4'd0));

        // Fill the ring and go past it, so that enqueues evict the oldest.
        for (int i = 0; i < SLOTS + 4; i++)
        begin
            pending_items.push_back(make_item(tofsq_pkg::OP_ENQUEUE, 8'(i % 5 + 1),
                                              $urandom(),
                                              20'($urandom_range(1, 20'hFFFFF)), 4'd0));
        end
        // Claim every slot, then enqueue into an all-claimed ring.
        for (int i = 0; i < SLOTS; i++)
        begin
            pending_items.push_back(make_item(tofsq_pkg::OP_TAKE, 8'd0, '0, '0, 4'd0));
        end
        pending_items.push_back(make_item(tofsq_pkg::OP_ENQUEUE, 8'd4, 32'hDEAD, 20'd9,
                                          4'd0));
        for (int i = 0; i < SLOTS; i++)
        begin
            pending_items.push_back(make_item(tofsq_pkg::OP_CLEAR, 8'd0, '0, '0, 4'(i)));
        end

        // Random part: small owner sets so that takes by owner hit often.
        for (int i = 0; i < 40; i++)
        begin
            it = random_item((i % 3 == 2) ? 0 : 4);
            pending_items.push_back(it);
            // Once a burst of enqueues then a full discard.
            if (i % 40 == 20)
            begin
                for (int j = 0; j < SLOTS + 2; j++)
                begin
                    pending_items.push_back(make_item(tofsq_pkg::OP_ENQUEUE,
                                                      8'($urandom_range(1, 255)),
                                                      $urandom(),
                                                      20'($urandom_range(1, 20'hFFFFF)),
                                                      4'd0));
                end
                pending_items.push_back(make_item(tofsq_pkg::OP_DISCARD, 8'd0, '0, '0,
                                                  4'd0));
            end
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_items.size() == 0 && !push);
        wait (expected_results.size() == 0);
        repeat (100) @(posedge clk);
        $display("Covered %0d items and %0d results, %0d of them evictions.",
                 items_sent, results_seen, evictions_seen);
        if (error_count == 0 && expected_results.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
